@@ design/cda_pkg.sv @@
package cda_pkg;

   // operation codes carried in the kind field
   localparam logic [2:0] KIND_DAYS    = 3'd0;
   localparam logic [2:0] KIND_WEEKS   = 3'd1;
   localparam logic [2:0] KIND_MONTHS  = 3'd2;
   localparam logic [2:0] KIND_YEARS   = 3'd3;
   localparam logic [2:0] KIND_DECADES = 3'd4;

   localparam logic [13:0] YEAR_MAX       = 14'd9999;
   // a 400 year jump from this year or below stays inside the range
   localparam logic [13:0] YEAR_CHUNK_TOP = 14'd9599;
   localparam logic [17:0] DAYS_PER_400Y  = 18'd146097;

   // divisibility by 25: multiply by the inverse of 25 mod 2^14
   localparam logic [13:0] INV25       = 14'd7209;
   localparam logic [13:0] DIV25_LIMIT = 14'd655;

   // floor(x / 12) = (x * RECIP12) >> RECIP12_SHIFT for x below 2^16
   localparam logic [16:0] RECIP12       = 17'd43691;
   localparam int          RECIP12_SHIFT = 19;

   typedef struct packed {
      logic load;
      logic prep;
      logic day_mon;
      logic day_chunk;
      logic day_year;
      logic mon_step;
      logic mon_div;
      logic mon_fin;
      logic publish;
   } cda_cmd_type;

   typedef struct packed {
      logic is_day;
      logic is_month;
      logic month_jan;
      logic mon_fits;
      logic mon_wrap;
      logic year_top;
      logic chunk_fits;
      logic chunk_high;
      logic year_fits;
      logic mstep_go;
   } cda_status_type;

   function automatic logic is_leap(input logic [13:0] year);
      logic [27:0] prod;
      logic        div25;
      prod  = year * INV25;
      div25 = (prod[13:0] <= DIV25_LIMIT);
      // multiple of 4, and not a century unless also a multiple of 16
      return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd2:                     len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ design/cda_req_if.sv @@
interface cda_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [14:0] amount;
   logic [4:0]  start_day;
   logic [3:0]  start_month;
   logic [13:0] start_year;

   modport source (output valid, output kind, output amount, output start_day,
                   output start_month, output start_year, input ready);
   modport sink (input valid, input kind, input amount, input start_day,
                 input start_month, input start_year, output ready);
endinterface

@@ design/cda_rsp_if.sv @@
interface cda_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  end_day;
   logic [3:0]  end_month;
   logic [13:0] end_year;
   logic        overflow;

   modport source (output valid, output end_day, output end_month, output end_year,
                   output overflow, input ready);
   modport sink (input valid, input end_day, input end_month, input end_year,
                 input overflow, output ready);
endinterface

@@ design/cda_dpath.sv @@
module cda_dpath import cda_pkg::*; (
   input  logic           clock,
   input  logic [2:0]     req_kind,
   input  logic [14:0]    req_amount,
   input  logic [4:0]     req_start_day,
   input  logic [3:0]     req_start_month,
   input  logic [13:0]    req_start_year,
   input  cda_cmd_type    cmd,
   output cda_status_type status,
   output logic [4:0]     end_day,
   output logic [3:0]     end_month,
   output logic [13:0]    end_year,
   output logic           overflow
);

   logic [2:0]  kind_ff, kind_in;
   logic [14:0] amount_ff, amount_in;
   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [13:0] year_ff, year_in;
   logic        ovf_ff, ovf_in;
   logic [17:0] rem_ff, rem_in;
   logic [11:0] quo_ff, quo_in;
   logic [4:0]  end_day_ff;
   logic [3:0]  end_month_ff;
   logic [13:0] end_year_ff;
   logic        end_ovf_ff;

   logic        leap_cur;
   logic [4:0]  len_cur, len_nx, day_clamped, ld_day;
   logic [3:0]  month_nx, ld_month;
   logic [13:0] year_inc, ld_year;
   logic [17:0] step_day, rem_prep, year_len;
   logic [18:0] year_add, year_sum;
   logic [15:0] div_num, quo_x12, div_rem;
   logic [32:0] div_prod;
   logic [14:0] year_fin;
   logic        is_year, sat;

   assign leap_cur = is_leap(year_ff);
   assign len_cur  = month_len(month_ff, leap_cur);
   assign month_nx = (month_ff == 4'd12) ? 4'd1 : month_ff + 4'd1;
   // a step into February never changes the year, so the current leap flag holds
   assign len_nx   = month_len(month_nx, leap_cur);
   assign year_inc = year_ff + 14'd1;

   assign step_day = (kind_ff == KIND_WEEKS) ?
                     ({amount_ff, 3'b000} - {3'b000, amount_ff}) : {3'b000, amount_ff};
   assign day_clamped = (day_ff > len_cur) ? len_cur : day_ff;
   // days counted from the first of the current month
   assign rem_prep = step_day + {13'd0, day_clamped} - 18'd1;
   assign year_len = leap_cur ? 18'd366 : 18'd365;

   assign year_add = (kind_ff == KIND_DECADES) ?
                     ({1'b0, amount_ff, 3'b000} + {3'b000, amount_ff, 1'b0}) :
                     {4'b0000, amount_ff};
   assign year_sum = {5'd0, year_ff} + year_add;
   assign is_year  = (kind_ff == KIND_YEARS) || (kind_ff == KIND_DECADES);

   assign div_num  = {12'd0, month_ff} - 16'd1 + {1'b0, rem_ff[14:0]};
   assign div_prod = div_num * RECIP12;
   assign quo_x12  = {1'b0, quo_ff, 3'b000} + {2'b00, quo_ff, 2'b00};
   assign div_rem  = div_num - quo_x12;
   assign year_fin = {1'b0, year_ff} + {3'b000, quo_ff};

   assign ld_day   = (req_start_day == 5'd0) ? 5'd1 : req_start_day;
   assign ld_month = (req_start_month == 4'd0) ? 4'd1 :
                     (req_start_month > 4'd12) ? 4'd12 : req_start_month;
   assign ld_year  = (req_start_year == 14'd0) ? 14'd1 :
                     (req_start_year > YEAR_MAX) ? YEAR_MAX : req_start_year;

   always_comb begin
      status.is_day     = (kind_ff == KIND_DAYS) || (kind_ff == KIND_WEEKS);
      status.is_month   = (kind_ff == KIND_MONTHS);
      status.month_jan  = (month_ff == 4'd1);
      status.mon_fits   = (rem_ff < {13'd0, len_cur});
      status.mon_wrap   = (month_ff == 4'd12);
      status.year_top   = (year_ff == YEAR_MAX);
      status.chunk_fits = (rem_ff < DAYS_PER_400Y);
      status.chunk_high = (year_ff > YEAR_CHUNK_TOP);
      status.year_fits  = (rem_ff < year_len);
      status.mstep_go   = (rem_ff != 18'd0) && (day_ff > 5'd28) && (year_ff <= YEAR_MAX);
   end

   always_comb begin
      kind_in   = kind_ff;
      amount_in = amount_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      ovf_in    = ovf_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      sat       = 1'b0;
      if (cmd.load) begin
         kind_in   = req_kind;
         amount_in = req_amount;
         day_in    = ld_day;
         month_in  = ld_month;
         year_in   = ld_year;
         ovf_in    = (req_start_year > YEAR_MAX);
      end else if (cmd.prep) begin
         if (status.is_day) begin
            rem_in = rem_prep;
         end else if (status.is_month) begin
            rem_in = {3'b000, amount_ff};
         end else if (is_year) begin
            if (year_sum > {5'd0, YEAR_MAX}) begin
               year_in = YEAR_MAX;
               ovf_in  = 1'b1;
            end else begin
               year_in = year_sum[13:0];
            end
         end
      end else if (cmd.day_mon) begin
         if (status.mon_fits) begin
            day_in = rem_ff[4:0] + 5'd1;
         end else begin
            rem_in = rem_ff - {13'd0, len_cur};
            if (status.mon_wrap) begin
               if (status.year_top) begin
                  sat = 1'b1;
               end else begin
                  month_in = 4'd1;
                  year_in  = year_inc;
               end
            end else begin
               month_in = month_nx;
            end
         end
      end else if (cmd.day_chunk) begin
         if (!status.chunk_fits) begin
            if (status.chunk_high) begin
               sat = 1'b1;
            end else begin
               rem_in  = rem_ff - DAYS_PER_400Y;
               year_in = year_ff + 14'd400;
            end
         end
      end else if (cmd.day_year) begin
         if (!status.year_fits) begin
            if (status.year_top) begin
               sat = 1'b1;
            end else begin
               rem_in  = rem_ff - year_len;
               year_in = year_inc;
            end
         end
      end else if (cmd.mon_step) begin
         // one month ahead, day clamped to the new month
         month_in = month_nx;
         year_in  = status.mon_wrap ? year_inc : year_ff;
         rem_in   = rem_ff - 18'd1;
         day_in   = (day_ff > len_nx) ? len_nx : day_ff;
      end else if (cmd.mon_div) begin
         quo_in = div_prod[RECIP12_SHIFT +: 12];
      end else if (cmd.mon_fin) begin
         if (year_fin > {1'b0, YEAR_MAX}) begin
            sat = 1'b1;
         end else begin
            year_in  = year_fin[13:0];
            month_in = div_rem[3:0] + 4'd1;
         end
      end
      if (sat) begin
         day_in   = 5'd31;
         month_in = 4'd12;
         year_in  = YEAR_MAX;
         ovf_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      amount_ff <= amount_in;
      day_ff    <= day_in;
      month_ff  <= month_in;
      year_ff   <= year_in;
      ovf_ff    <= ovf_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         end_day_ff   <= day_ff;
         end_month_ff <= month_ff;
         end_year_ff  <= year_ff;
         end_ovf_ff   <= ovf_ff;
      end
   end

   assign end_day   = end_day_ff;
   assign end_month = end_month_ff;
   assign end_year  = end_year_ff;
   assign overflow  = end_ovf_ff;

endmodule

@@ design/cda_ctrl.sv @@
module cda_ctrl import cda_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  cda_status_type status,
   output cda_cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_PREP      = 9'b000000010,
      ST_DAY_MON   = 9'b000000100,
      ST_DAY_CHUNK = 9'b000001000,
      ST_DAY_YEAR  = 9'b000010000,
      ST_MON_STEP  = 9'b000100000,
      ST_MON_DIV   = 9'b001000000,
      ST_MON_FIN   = 9'b010000000,
      ST_DONE      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (status.is_day) begin
               state_in = status.month_jan ? ST_DAY_CHUNK : ST_DAY_MON;
            end else if (status.is_month) begin
               state_in = ST_MON_STEP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DAY_MON: begin
            cmd.day_mon = 1'b1;
            if (status.mon_fits) begin
               state_in = ST_DONE;
            end else if (status.mon_wrap) begin
               state_in = status.year_top ? ST_DONE : ST_DAY_CHUNK;
            end
         end
         ST_DAY_CHUNK: begin
            cmd.day_chunk = 1'b1;
            if (status.chunk_fits) begin
               state_in = ST_DAY_YEAR;
            end else if (status.chunk_high) begin
               state_in = ST_DONE;
            end
         end
         ST_DAY_YEAR: begin
            cmd.day_year = 1'b1;
            if (status.year_fits) begin
               state_in = ST_DAY_MON;
            end else if (status.year_top) begin
               state_in = ST_DONE;
            end
         end
         ST_MON_STEP: begin
            // single steps only while the day clamp can still bite
            if (status.mstep_go) begin
               cmd.mon_step = 1'b1;
            end else begin
               state_in = ST_MON_DIV;
            end
         end
         ST_MON_DIV: begin
            cmd.mon_div = 1'b1;
            state_in    = ST_MON_FIN;
         end
         ST_MON_FIN: begin
            cmd.mon_fin = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

@@ design/calendar_date_adder_top.sv @@
// Gregorian date adder: adds days, weeks, months, years or decades to a date.
// req_bus carries one transaction per operation: kind, amount and the start
// date. rsp_bus returns exactly one transaction with the end date and an
// overflow flag; results come back in request order.
// Steps from request accept to result valid:
//   years, decades and unused kinds: straight to the output register
//   months: single month steps while the day is above 28 and months
//     remain, then a divide by 12 and a final step that sets month and year
//   days and weeks: a walk month by month; a walk that starts in or reaches
//     January skips whole 400 year blocks, then single years, then walks
//     the remaining months
// The sequencer walks months and years one per cycle; that loop sets the
// throughput. One operation is in flight at a time; a new request is taken
// once the previous result has moved into the output register, even while
// that result still waits for rsp ready.
// A stalled receiver holds the output register and keeps the next result
// in the datapath until the slot frees up.
// Synchronous reset clears the sequencer and drops rsp valid; nothing else
// needs clearing.
module calendar_date_adder_top import cda_pkg::*; (
   input logic       clock,
   input logic       reset,
   cda_req_if.sink   req_bus,
   cda_rsp_if.source rsp_bus
);

   cda_cmd_type    cmd;
   cda_status_type status;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cda_dpath u_dpath (
      .clock           (clock),
      .req_kind        (req_bus.kind),
      .req_amount      (req_bus.amount),
      .req_start_day   (req_bus.start_day),
      .req_start_month (req_bus.start_month),
      .req_start_year  (req_bus.start_year),
      .cmd             (cmd),
      .status          (status),
      .end_day         (rsp_bus.end_day),
      .end_month       (rsp_bus.end_month),
      .end_year        (rsp_bus.end_year),
      .overflow        (rsp_bus.overflow)
   );

endmodule

@@ design/cda_checker.sv @@
module cda_checker import cda_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_end_day,
   input logic [3:0]  rsp_end_month,
   input logic [13:0] rsp_end_year,
   input logic        rsp_overflow
);

   // no result left over after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_end_day) &&
      $stable(rsp_end_month) && $stable(rsp_end_year) && $stable(rsp_overflow))
      else $error("stalled result changed");

   // every result is a date inside the supported range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_end_day != 5'd0 && rsp_end_month != 4'd0 &&
      rsp_end_month <= 4'd12 && rsp_end_year != 14'd0 && rsp_end_year <= YEAR_MAX)
      else $error("result date out of range");

   // overflow always comes with the year pinned at the top
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_end_year == YEAR_MAX)
      else $error("overflow without saturated year");

   // one operation at a time: no back to back requests
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind calendar_date_adder_top cda_checker u_cda_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_end_day   (rsp_bus.end_day),
   .rsp_end_month (rsp_bus.end_month),
   .rsp_end_year  (rsp_bus.end_year),
   .rsp_overflow  (rsp_bus.overflow)
);

@@ tb/tb_calendar_date_adder_top.sv @@
module tb_calendar_date_adder_top import cda_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DAYS_PER_WEEK    = 7;
   localparam int unsigned MONTHS_PER_YEAR  = 12;
   localparam int unsigned YEARS_PER_DECADE = 10;
   localparam int unsigned LAST_DAY         = 31;
   localparam int unsigned CLAMP_FLOOR      = 28;
   localparam int unsigned KIND_TOP         = 7;
   localparam int unsigned AMOUNT_TOP       = 32767;
   localparam int unsigned YEAR_FIELD_TOP   = 16383;
   localparam int unsigned SETTLE_CYCLES    = 500;
   localparam int unsigned STALL_CYCLES     = 300;

   typedef struct {
      logic [2:0]  kind;
      logic [14:0] amount;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } date_req_type;

   typedef struct {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic        overflow;
   } date_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cda_req_if req_bus ();
   cda_rsp_if rsp_bus ();

   calendar_date_adder_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   date_rsp_type expected_dates[$];
   date_rsp_type oldest_date;
   int unsigned  mismatch_count = 0;
   int unsigned  rsp_hold_cycles = 0;
   bit           no_idle = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.kind        = '0;
      req_bus.amount      = '0;
      req_bus.start_day   = '0;
      req_bus.start_month = '0;
      req_bus.start_year  = '0;
      rsp_bus.ready       = 1'b0;
   end

   // ---------------- date arithmetic ----------------

   function automatic bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
      int unsigned len;
      case (m)
         2:           len = leap_year(y) ? 29 : 28;
         4, 6, 9, 11: len = 30;
         default:     len = 31;
      endcase
      return len;
   endfunction

   // day count since a fixed epoch, March-based year
   function automatic int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
      int unsigned yy, era, yoe, mm, doy, doe;
      yy  = (m <= 2) ? y - 1 : y;
      era = yy / 400;
      yoe = yy - era * 400;
      mm  = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mm + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe;
   endfunction

   function automatic void date_from_number(input int unsigned z, output int unsigned y,
                                            output int unsigned m, output int unsigned d);
      int unsigned era, doe, yoe, doy, mp, yy;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      yy  = yoe + era * 400;
      d   = doy - (153 * mp + 2) / 5 + 1;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      if (m <= 2) yy++;
      y = yy;
   endfunction

   function automatic date_rsp_type predict_date(date_req_type r);
      int unsigned d, m, y, ovf, amt, len, step, serial, left, total;
      date_rsp_type res;
      d   = r.day;
      m   = r.month;
      y   = r.year;
      amt = r.amount;
      ovf = 0;
      if (d == 0) d = 1;
      if (m == 0) m = 1;
      if (m > MONTHS_PER_YEAR) m = MONTHS_PER_YEAR;
      if (y == 0) y = 1;
      if (y > YEAR_MAX) begin
         y   = YEAR_MAX;
         ovf = 1;
      end
      case (r.kind)
         KIND_DAYS, KIND_WEEKS: begin
            len  = days_in_month(m, y);
            step = (r.kind == KIND_WEEKS) ? amt * DAYS_PER_WEEK : amt;
            if (d > len) d = len;
            serial = day_number(y, m, d) + step;
            if (serial > day_number(YEAR_MAX, MONTHS_PER_YEAR, LAST_DAY)) begin
               y   = YEAR_MAX;
               m   = MONTHS_PER_YEAR;
               d   = LAST_DAY;
               ovf = 1;
            end else begin
               date_from_number(serial, y, m, d);
            end
         end
         KIND_MONTHS: begin
            left = amt;
            // single steps only matter while the clamp can still lower the day
            while (left != 0 && d > CLAMP_FLOOR && y <= YEAR_MAX) begin
               if (m == MONTHS_PER_YEAR) begin
                  m = 1;
                  y++;
               end else begin
                  m++;
               end
               left--;
               if (y <= YEAR_MAX) begin
                  len = days_in_month(m, y);
                  if (d > len) d = len;
               end
            end
            total = y * MONTHS_PER_YEAR + (m - 1) + left;
            y     = total / MONTHS_PER_YEAR;
            m     = total % MONTHS_PER_YEAR + 1;
            if (y > YEAR_MAX) begin
               y   = YEAR_MAX;
               m   = MONTHS_PER_YEAR;
               d   = LAST_DAY;
               ovf = 1;
            end
         end
         KIND_YEARS, KIND_DECADES: begin
            y = y + ((r.kind == KIND_DECADES) ? amt * YEARS_PER_DECADE : amt);
            if (y > YEAR_MAX) begin
               y   = YEAR_MAX;
               ovf = 1;
            end
         end
         default: ;
      endcase
      res.day      = d[4:0];
      res.month    = m[3:0];
      res.year     = y[13:0];
      res.overflow = ovf[0];
      return res;
   endfunction

   // ---------------- channel handling ----------------

   function automatic date_req_type make_req(int unsigned kind, int unsigned amount,
                                             int unsigned d, int unsigned m, int unsigned y);
      date_req_type r;
      r.kind   = kind[2:0];
      r.amount = amount[14:0];
      r.day    = d[4:0];
      r.month  = m[3:0];
      r.year   = y[13:0];
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      if (no_idle || $urandom_range(99) >= 33) return 0;
      return $urandom_range(4, 1);
   endfunction

   task automatic issue_date_request(date_req_type r);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.kind        <= r.kind;
      req_bus.amount      <= r.amount;
      req_bus.start_day   <= r.day;
      req_bus.start_month <= r.month;
      req_bus.start_year  <= r.year;
      req_bus.valid       <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      expected_dates.push_back(predict_date(r));
   endtask

   // drop valid after the last accepted transaction and wait for every result
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_hold_cycles = rsp_hold_cycles - 1;
            rsp_bus.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 33);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_dates.size() == 0) begin
            $error("unexpected result transaction: %0d-%0d-%0d overflow %0b",
                   rsp_bus.end_year, rsp_bus.end_month, rsp_bus.end_day, rsp_bus.overflow);
            mismatch_count++;
         end else begin
            oldest_date = expected_dates.pop_front();
            if (rsp_bus.end_day !== oldest_date.day) begin
               $error("end_day mismatch: expected %0d, actual %0d",
                      oldest_date.day, rsp_bus.end_day);
               mismatch_count++;
            end
            if (rsp_bus.end_month !== oldest_date.month) begin
               $error("end_month mismatch: expected %0d, actual %0d",
                      oldest_date.month, rsp_bus.end_month);
               mismatch_count++;
            end
            if (rsp_bus.end_year !== oldest_date.year) begin
               $error("end_year mismatch: expected %0d, actual %0d",
                      oldest_date.year, rsp_bus.end_year);
               mismatch_count++;
            end
            if (rsp_bus.overflow !== oldest_date.overflow) begin
               $error("overflow mismatch: expected %0b, actual %0b",
                      oldest_date.overflow, rsp_bus.overflow);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------- stimulus ----------------

   function automatic date_req_type random_date_request();
      date_req_type r;
      int unsigned  sel, y, m, d, len, amt;
      // a share of raw field noise, the rest well formed dates
      if ($urandom_range(99) < 15) begin
         return make_req($urandom_range(KIND_TOP), $urandom_range(AMOUNT_TOP),
                         $urandom_range(31), $urandom_range(15),
                         $urandom_range(YEAR_FIELD_TOP));
      end
      sel = $urandom_range(9);
      if (sel < 6)       y = $urandom_range(YEAR_MAX, 1);
      else if (sel < 8)  y = $urandom_range(YEAR_MAX, YEAR_MAX - 99);
      else if (sel == 8) y = $urandom_range(99, 1) * 100;
      else               y = $urandom_range(50, 1);
      m   = $urandom_range(MONTHS_PER_YEAR, 1);
      len = days_in_month(m, y);
      d   = ($urandom_range(3) == 0) ? $urandom_range(len, CLAMP_FLOOR)
                                     : $urandom_range(len, 1);
      sel = $urandom_range(9);
      if (sel < 5)      amt = $urandom_range(60);
      else if (sel < 8) amt = $urandom_range(3000);
      else              amt = $urandom_range(AMOUNT_TOP);
      r = make_req($urandom_range(KIND_DECADES), amt, d, m, y);
      return r;
   endfunction

   task automatic test_day_steps();
      issue_date_request(make_req(KIND_DAYS, 0, 1, 1, 1));
      issue_date_request(make_req(KIND_DAYS, 1, 31, 12, 1999));
      issue_date_request(make_req(KIND_DAYS, 1, 28, 2, 2000));
      issue_date_request(make_req(KIND_DAYS, 1, 28, 2, 1900));
      issue_date_request(make_req(KIND_DAYS, AMOUNT_TOP, 1, 1, 1));
      issue_date_request(make_req(KIND_WEEKS, AMOUNT_TOP, 1, 1, 9000));
      issue_date_request(make_req(KIND_WEEKS, AMOUNT_TOP, 1, 1, YEAR_MAX));
      // one past the last representable day
      issue_date_request(make_req(KIND_DAYS, 1, 31, 12, YEAR_MAX));
      // day past the end of february is pulled back first
      issue_date_request(make_req(KIND_DAYS, 0, 31, 2, 2001));
   endtask

   task automatic test_month_steps();
      issue_date_request(make_req(KIND_MONTHS, 1, 31, 1, 2023));
      issue_date_request(make_req(KIND_MONTHS, 13, 31, 1, 2024));
      issue_date_request(make_req(KIND_MONTHS, AMOUNT_TOP, 31, 12, YEAR_MAX));
      issue_date_request(make_req(KIND_MONTHS, 0, 31, 2, 2023));
      issue_date_request(make_req(KIND_MONTHS, 1, 15, 12, YEAR_MAX));
      issue_date_request(make_req(KIND_MONTHS, AMOUNT_TOP, 1, 1, 1));
   endtask

   task automatic test_year_steps();
      // feb 29 survives a year step
      issue_date_request(make_req(KIND_YEARS, 1, 29, 2, 2024));
      issue_date_request(make_req(KIND_YEARS, AMOUNT_TOP, 1, 1, 1));
      issue_date_request(make_req(KIND_YEARS, 0, 31, 12, YEAR_MAX));
      issue_date_request(make_req(KIND_DECADES, 3, 10, 6, 2000));
      issue_date_request(make_req(KIND_DECADES, AMOUNT_TOP, 31, 4, 1));
   endtask

   task automatic test_input_corrections();
      issue_date_request(make_req(KIND_DAYS, 5, 0, 0, 0));
      issue_date_request(make_req(KIND_MONTHS, 2, 31, 15, 2020));
      issue_date_request(make_req(KIND_YEARS, 0, 31, 13, YEAR_FIELD_TOP));
      issue_date_request(make_req(KIND_DAYS, 0, 31, 2, YEAR_MAX + 1));
      for (int unsigned k = KIND_DECADES + 1; k <= KIND_TOP; k++) begin
         issue_date_request(make_req(k, $urandom_range(AMOUNT_TOP), 31, 2, 1900));
      end
   endtask

   task automatic test_random_traffic(int unsigned count, bit quiet);
      no_idle = quiet;
      repeat (count) issue_date_request(random_date_request());
      no_idle = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering transactions
   task automatic test_output_stall();
      rsp_hold_cycles = STALL_CYCLES;
      repeat (12) issue_date_request(random_date_request());
   endtask

   task automatic test_sender_pause();
      repeat (10) issue_date_request(random_date_request());
      drain_results();
      repeat (10) issue_date_request(random_date_request());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_day_steps();
      test_month_steps();
      test_year_steps();
      test_input_corrections();
      test_random_traffic(500, 1'b0);
      test_output_stall();
      test_random_traffic(150, 1'b1);
      test_sender_pause();
      test_random_traffic(400, 1'b0);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_dates.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("tb: failure");
      $finish;
   end

endmodule
